// File: src/mqsp_pkg.sv
package mqsp_pkg;

    // Default sizing of the queue bank
    localparam int NUM_QUEUES_DEF    = 10;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int SEVERITY_BITS_DEF = 4;
    localparam int TIME_BITS_DEF     = 16;

    // Port field widths
    localparam int MODE_W      = 2;
    localparam int QID_W       = 4;
    localparam int SEV_PORT_W  = 4;
    localparam int TIME_PORT_W = 16;
    localparam int ID_W        = 16;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT,
        MODE_POP,
        MODE_QUERY,
        MODE_NOP
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_NOT_FOUND,
        ST_FULL
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Command broadcast to every cell of one queue's chain
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

// File: src/mqsp_cell.sv
module mqsp_cell
    import mqsp_pkg::*;
#(
    parameter int SEV_W  = SEVERITY_BITS_DEF,
    parameter int TIME_W = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic              i_valid,
    input  logic [SEV_W-1:0]  i_new_sev,
    input  logic [TIME_W-1:0] i_new_time,
    input  logic [ID_W-1:0]   i_new_id,
    input  logic              i_prev_ahead,
    input  logic [SEV_W-1:0]  i_prev_sev,
    input  logic [TIME_W-1:0] i_prev_time,
    input  logic [ID_W-1:0]   i_prev_id,
    input  logic [SEV_W-1:0]  i_next_sev,
    input  logic [TIME_W-1:0] i_next_time,
    input  logic [ID_W-1:0]   i_next_id,
    output logic              o_ahead,
    output logic [SEV_W-1:0]  o_sev,
    output logic [TIME_W-1:0] o_time,
    output logic [ID_W-1:0]   o_id
);

    logic [SEV_W-1:0]  r_sev;
    logic [TIME_W-1:0] r_time;
    logic [ID_W-1:0]   r_id;
    logic              w_new_beats;

    // New request overtakes this entry only on a strictly better key,
    // so equal keys stay in insertion order.
    assign w_new_beats = (i_new_sev > r_sev) ||
                         ((i_new_sev == r_sev) && (i_new_time < r_time));
    assign o_ahead = i_valid && !w_new_beats;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_sev  <= i_next_sev;
            r_time <= i_next_time;
            r_id   <= i_next_id;
        end else if (i_cmd.ins && !o_ahead) begin
            if (i_prev_ahead) begin
                r_sev  <= i_new_sev;
                r_time <= i_new_time;
                r_id   <= i_new_id;
            end else begin
                r_sev  <= i_prev_sev;
                r_time <= i_prev_time;
                r_id   <= i_prev_id;
            end
        end
    end

    assign o_sev  = r_sev;
    assign o_time = r_time;
    assign o_id   = r_id;

endmodule

// File: src/mqsp_chain.sv
module mqsp_chain
    import mqsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SEV_W       = SEVERITY_BITS_DEF,
    parameter int TIME_W      = TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cell_cmd                        i_cmd,
    input  logic [SEV_W-1:0]                 i_new_sev,
    input  logic [TIME_W-1:0]                i_new_time,
    input  logic [ID_W-1:0]                  i_new_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count,
    output logic                             o_created,
    output logic [SEV_W-1:0]                 o_head_sev,
    output logic [TIME_W-1:0]                o_head_time,
    output logic [ID_W-1:0]                  o_head_id
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic              r_created;
    logic              w_ahead [QUEUE_DEPTH];
    logic [SEV_W-1:0]  w_sev   [QUEUE_DEPTH];
    logic [TIME_W-1:0] w_time  [QUEUE_DEPTH];
    logic [ID_W-1:0]   w_id    [QUEUE_DEPTH];

    // Cells stay sorted: cell 0 holds the entry that leaves next.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

        mqsp_cell #(
            .SEV_W  (SEV_W),
            .TIME_W (TIME_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_valid      (r_count > CNT_W'(i)),
            .i_new_sev    (i_new_sev),
            .i_new_time   (i_new_time),
            .i_new_id     (i_new_id),
            .i_prev_ahead ((i == 0) ? 1'b1 : w_ahead[PREV]),
            .i_prev_sev   (w_sev[PREV]),
            .i_prev_time  (w_time[PREV]),
            .i_prev_id    (w_id[PREV]),
            .i_next_sev   (w_sev[NEXT]),
            .i_next_time  (w_time[NEXT]),
            .i_next_id    (w_id[NEXT]),
            .o_ahead      (w_ahead[i]),
            .o_sev        (w_sev[i]),
            .o_time       (w_time[i]),
            .o_id         (w_id[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_created <= 1'b0;
        end else if (i_cmd.ins) begin
            r_count   <= r_count + CNT_W'(1);
            r_created <= 1'b1;
        end else if (i_cmd.pop) begin
            r_count   <= r_count - CNT_W'(1);
        end
    end

    assign o_count     = r_count;
    assign o_created   = r_created;
    assign o_head_sev  = w_sev[0];
    assign o_head_time = w_time[0];
    assign o_head_id   = w_id[0];

endmodule

// File: src/multi_queue_severity_priority_queue.sv
// Channel   Valid         Stall         Payload
// request   i_in_valid    o_in_stall    i_mode, i_queue_id, i_severity, i_arrival_time,
//                                       i_entry_id
// result    o_out_valid   i_out_stall   o_status, o_out_id, o_out_severity, o_out_arrival,
//                                       o_is_empty
//
// Each request is captured in the request registers; then, in the execute state, the
// queue's cell chain inserts (parallel compare in every cell) or pops (shift toward the
// head) and the result register is loaded. A new request is taken while a result waits
// in the output register. Reset clears counts and created flags; no clearing pass is
// needed. A stalled result keeps the next request in execute until the result is taken.
module multi_queue_severity_priority_queue
    import mqsp_pkg::*;
#(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int SEVERITY_BITS = SEVERITY_BITS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [QID_W-1:0]       i_queue_id,
    input  logic [SEV_PORT_W-1:0]  i_severity,
    input  logic [TIME_PORT_W-1:0] i_arrival_time,
    input  logic [ID_W-1:0]        i_entry_id,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ID_W-1:0]        o_out_id,
    output logic [SEV_PORT_W-1:0]  o_out_severity,
    output logic [TIME_PORT_W-1:0] o_out_arrival,
    output logic                   o_is_empty
);

    localparam int SEV_W  = (SEVERITY_BITS < SEV_PORT_W) ? SEVERITY_BITS : SEV_PORT_W;
    localparam int TIME_W = (TIME_BITS < TIME_PORT_W) ? TIME_BITS : TIME_PORT_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [QID_W-1:0]  r_qid;
    logic [SEV_W-1:0]  r_sev;
    logic [TIME_W-1:0] r_time;
    logic [ID_W-1:0]   r_id;

    logic              r_out_valid;
    t_status           r_status;
    logic [ID_W-1:0]   r_out_id;
    logic [SEV_W-1:0]  r_out_sev;
    logic [TIME_W-1:0] r_out_time;
    logic              r_is_empty;

    logic [CNT_W-1:0]  w_cnt       [NUM_QUEUES];
    logic              w_created   [NUM_QUEUES];
    logic [SEV_W-1:0]  w_head_sev  [NUM_QUEUES];
    logic [TIME_W-1:0] w_head_time [NUM_QUEUES];
    logic [ID_W-1:0]   w_head_id   [NUM_QUEUES];

    logic              w_accept;
    logic              w_fire;
    logic              w_in_range;
    logic [CNT_W-1:0]  w_sel_cnt;
    logic              w_sel_created;
    logic [SEV_W-1:0]  w_sel_sev;
    logic [TIME_W-1:0] w_sel_time;
    logic [ID_W-1:0]   w_sel_id;
    logic              w_do_ins;
    logic              w_do_pop;
    t_status           w_status;
    logic              w_is_empty;
    logic              w_take_head;

    assign w_accept = i_in_valid && !o_in_stall;

    // Request capture; keys are masked to their configured widths here
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_mode);
            r_qid  <= i_queue_id;
            r_sev  <= i_severity[SEV_W-1:0];
            r_time <= i_arrival_time[TIME_W-1:0];
            r_id   <= i_entry_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_in_stall = 1'b1;
                // advance only once the result register is free
                w_fire = !r_out_valid || !i_out_stall;
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Look at the addressed queue
    assign w_in_range = int'(r_qid) < NUM_QUEUES;

    always_comb begin
        w_sel_cnt     = '0;
        w_sel_created = 1'b0;
        w_sel_sev     = '0;
        w_sel_time    = '0;
        w_sel_id      = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (int'(r_qid) == q) begin
                w_sel_cnt     = w_cnt[q];
                w_sel_created = w_created[q];
                w_sel_sev     = w_head_sev[q];
                w_sel_time    = w_head_time[q];
                w_sel_id      = w_head_id[q];
            end
        end
    end

    always_comb begin
        w_status    = ST_OK;
        w_is_empty  = 1'b0;
        w_take_head = 1'b0;
        w_do_ins    = 1'b0;
        w_do_pop    = 1'b0;
        if (r_mode == MODE_NOP) begin
            w_status = ST_OK;
        end else if (!w_in_range) begin
            w_status   = ST_NOT_FOUND;
            w_is_empty = 1'b1;
        end else begin
            case (r_mode)
                MODE_INSERT: begin
                    if (w_sel_cnt == CNT_W'(QUEUE_DEPTH)) begin
                        w_status = ST_FULL;
                    end else begin
                        w_do_ins = 1'b1;
                    end
                end
                MODE_POP: begin
                    if (!w_sel_created) begin
                        w_status   = ST_NOT_FOUND;
                        w_is_empty = 1'b1;
                    end else if (w_sel_cnt == '0) begin
                        w_status   = ST_EMPTY;
                        w_is_empty = 1'b1;
                    end else begin
                        w_do_pop    = 1'b1;
                        w_take_head = 1'b1;
                        w_is_empty  = (w_sel_cnt == CNT_W'(1));
                    end
                end
                MODE_QUERY: begin
                    w_is_empty = !w_sel_created || (w_sel_cnt == '0);
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        t_cell_cmd w_cmd;

        assign w_cmd.ins = w_fire && w_do_ins && (int'(r_qid) == q);
        assign w_cmd.pop = w_fire && w_do_pop && (int'(r_qid) == q);

        mqsp_chain #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .SEV_W       (SEV_W),
            .TIME_W      (TIME_W)
        ) u_chain (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_new_sev   (r_sev),
            .i_new_time  (r_time),
            .i_new_id    (r_id),
            .o_count     (w_cnt[q]),
            .o_created   (w_created[q]),
            .o_head_sev  (w_head_sev[q]),
            .o_head_time (w_head_time[q]),
            .o_head_id   (w_head_id[q])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status   <= w_status;
            r_is_empty <= w_is_empty;
            r_out_id   <= w_take_head ? w_sel_id : '0;
            r_out_sev  <= w_take_head ? w_sel_sev : '0;
            r_out_time <= w_take_head ? w_sel_time : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_severity = SEV_PORT_W'(r_out_sev);
    assign o_out_arrival  = TIME_PORT_W'(r_out_time);
    assign o_is_empty     = r_is_empty;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("request accepted without entering execute");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && w_in_range |-> w_sel_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("executed request gave no result");

    a_not_found_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_NOT_FOUND) |-> r_is_empty)
        else $error("missing queue reported as non-empty");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import mqsp_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [SEV_PORT_W-1:0]  sev;
        logic [TIME_PORT_W-1:0] arrival;
        logic [ID_W-1:0]        id;
    } t_bank_entry;

    typedef struct packed {
        t_status                status;
        logic [ID_W-1:0]        id;
        logic [SEV_PORT_W-1:0]  sev;
        logic [TIME_PORT_W-1:0] arrival;
        logic                   empty;
    } t_bank_result;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [MODE_W-1:0]      i_mode = '0;
    logic [QID_W-1:0]       i_queue_id = '0;
    logic [SEV_PORT_W-1:0]  i_severity = '0;
    logic [TIME_PORT_W-1:0] i_arrival_time = '0;
    logic [ID_W-1:0]        i_entry_id = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_out_id;
    logic [SEV_PORT_W-1:0]  o_out_severity;
    logic [TIME_PORT_W-1:0] o_out_arrival;
    logic                   o_is_empty;

    // Predicted queue bank: entries packed in insertion order per queue
    t_bank_entry  bank_slots   [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
    int           bank_count   [NUM_QUEUES_DEF];
    bit           bank_created [NUM_QUEUES_DEF];
    t_bank_result owed_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    multi_queue_severity_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_queue_id     (i_queue_id),
        .i_severity     (i_severity),
        .i_arrival_time (i_arrival_time),
        .i_entry_id     (i_entry_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_severity (o_out_severity),
        .o_out_arrival  (o_out_arrival),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_bank_result apply_to_bank(
        input t_mode                  m,
        input logic [QID_W-1:0]       q,
        input logic [SEV_PORT_W-1:0]  sev,
        input logic [TIME_PORT_W-1:0] arr,
        input logic [ID_W-1:0]        id
    );
        t_bank_result r;
        int qi;
        int n;
        int best;
        int s;
        r = '0;
        r.status = ST_OK;
        qi = int'(q);
        if (m == MODE_NOP)
            return r;
        if (qi >= NUM_QUEUES_DEF) begin
            r.status = ST_NOT_FOUND;
            r.empty = 1'b1;
            return r;
        end
        n = bank_count[qi];
        case (m)
            MODE_INSERT: begin
                bank_created[qi] = 1'b1;
                if (n >= QUEUE_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    bank_slots[qi][n] = '{sev: sev, arrival: arr, id: id};
                    bank_count[qi] = n + 1;
                end
            end
            MODE_POP: begin
                if (!bank_created[qi]) begin
                    r.status = ST_NOT_FOUND;
                end else if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // strict compare keeps the earliest insert on a full tie
                    best = 0;
                    for (s = 1; s < n; s++) begin
                        if (bank_slots[qi][s].sev > bank_slots[qi][best].sev ||
                            (bank_slots[qi][s].sev == bank_slots[qi][best].sev &&
                             bank_slots[qi][s].arrival < bank_slots[qi][best].arrival))
                            best = s;
                    end
                    r.id = bank_slots[qi][best].id;
                    r.sev = bank_slots[qi][best].sev;
                    r.arrival = bank_slots[qi][best].arrival;
                    for (s = best; s + 1 < n; s++)
                        bank_slots[qi][s] = bank_slots[qi][s + 1];
                    bank_count[qi] = n - 1;
                end
            end
            default: ;
        endcase
        r.empty = !bank_created[qi] || bank_count[qi] == 0;
        return r;
    endfunction

    task automatic send_request(
        input t_mode                  m,
        input logic [QID_W-1:0]       q,
        input logic [SEV_PORT_W-1:0]  sev,
        input logic [TIME_PORT_W-1:0] arr,
        input logic [ID_W-1:0]        id
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_queue_id <= q;
        i_severity <= sev;
        i_arrival_time <= arr;
        i_entry_id <= id;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        owed_results.push_back(apply_to_bank(m, q, sev, arr, id));
    endtask

    always @(posedge i_clk) begin
        t_bank_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: status %0d id %h sev %h arrival %h empty %b",
                             o_status, o_out_id, o_out_severity, o_out_arrival, o_is_empty);
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status || o_out_id !== want.id ||
                    o_out_severity !== want.sev || o_out_arrival !== want.arrival ||
                    o_is_empty !== want.empty) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch expected: status %0d id %h sev %h arrival %h empty %b",
                                 want.status, want.id, want.sev, want.arrival, want.empty);
                        $display("         actual:   status %0d id %h sev %h arrival %h empty %b",
                                 o_status, o_out_id, o_out_severity, o_out_arrival,
                                 o_is_empty);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_request(MODE_QUERY, 0, 4'h5, 16'h1111, 16'h2222);
        send_request(MODE_POP, 0, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_INSERT, 0, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_POP, 0, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_POP, 0, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_QUERY, 0, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_INSERT, 9, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_INSERT, 9, 4'hF, 16'h0000, 16'h1234);
        send_request(MODE_INSERT, 9, 4'h3, 16'h0000, 16'h0001);
        // same keys as the second entry: must leave after it
        send_request(MODE_INSERT, 9, 4'hF, 16'h0000, 16'h5678);
        send_request(MODE_QUERY, 9, 4'h0, 16'h0000, 16'h0000);
        repeat (4) send_request(MODE_POP, 9, 4'hA, 16'hAAAA, 16'h5555);
        send_request(MODE_POP, 9, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_INSERT, 10, 4'h7, 16'h0042, 16'h0099);
        send_request(MODE_POP, 15, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_QUERY, 12, 4'h0, 16'h0000, 16'h0000);
        send_request(MODE_NOP, 3, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_NOP, 14, 4'h0, 16'h0000, 16'h0000);
    endtask

    task automatic test_full_queue();
        repeat (QUEUE_DEPTH_DEF)
            send_request(MODE_INSERT, 5, SEV_PORT_W'($urandom_range(15)),
                         TIME_PORT_W'($urandom_range(7)), ID_W'($urandom));
        // drop: queue at capacity
        send_request(MODE_INSERT, 5, 4'hF, 16'h0000, 16'hBEEF);
        send_request(MODE_INSERT, 5, 4'h0, 16'hFFFF, 16'h0000);
        send_request(MODE_QUERY, 5, 4'h0, 16'h0000, 16'h0000);
        repeat (QUEUE_DEPTH_DEF + 1)
            send_request(MODE_POP, 5, SEV_PORT_W'($urandom), TIME_PORT_W'($urandom),
                         ID_W'($urandom));
    endtask

    task automatic test_random(input int count);
        int ins_pct;
        int roll;
        t_mode m;
        logic [QID_W-1:0] q;
        logic [SEV_PORT_W-1:0] sev;
        logic [TIME_PORT_W-1:0] arr;
        ins_pct = 50;
        for (int k = 0; k < count; k++) begin
            // pick a fill-heavy, balanced or drain-heavy mix for each stretch of 40 requests
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: ins_pct = 30;
                    1: ins_pct = 50;
                    default: ins_pct = 70;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < ins_pct)
                m = MODE_INSERT;
            else if (roll < 88)
                m = MODE_POP;
            else if (roll < 96)
                m = MODE_QUERY;
            else
                m = MODE_NOP;
            roll = $urandom_range(99);
            if (roll < 6)
                q = QID_W'($urandom_range(15, 10));
            else if (roll < 66)
                q = QID_W'($urandom_range(2));
            else
                q = QID_W'($urandom_range(9));
            roll = $urandom_range(99);
            if (roll < 50)
                sev = SEV_PORT_W'($urandom);
            else if (roll < 70)
                sev = SEV_PORT_W'($urandom_range(8, 7));
            else if (roll < 85)
                sev = '0;
            else
                sev = '1;
            roll = $urandom_range(99);
            if (roll < 40)
                arr = TIME_PORT_W'($urandom);
            else if (roll < 80)
                arr = TIME_PORT_W'($urandom_range(3));
            else if (roll < 90)
                arr = '0;
            else
                arr = '1;
            send_request(m, q, sev, arr, ID_W'($urandom));
        end
    endtask

    initial begin
        send_idle_pct = 21;
        recv_stall_pct = 86;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_queue();
        test_random(550);
        send_idle_pct = 86;
        recv_stall_pct = 21;
        test_random(550);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(550);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
